// File: rtl/ltst_pkg.sv
package ltst_pkg;

  // Table geometry.
  localparam int TABLE_SLOTS = 64;
  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

  // Queue between the front and the back, a power of two of at least two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic CFG_MAX_LEN = 1'b0;
  localparam logic CFG_MIN_LEN = 1'b1;

  // Configuration reset values.
  localparam logic [31:0] MAX_LEN_RESET = 32'd16777216;
  localparam logic [15:0] MIN_LEN_RESET = 16'd24;

  typedef enum logic [2:0] {
    ACT_FORWARD = 3'd0,
    ACT_SKIP    = 3'd1,
    ACT_BADLEN  = 3'd2,
    ACT_FULL    = 3'd3,
    ACT_FINISH  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_PROGRESS  = 2'd0,
    ST_COMMITTED = 2'd1,
    ST_ABORTED   = 2'd2,
    ST_NONE      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_CHECKPOINT = 2'd1,
    KIND_COMMIT     = 2'd2,
    KIND_ABORT      = 2'd3
  } kind_t;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_FINISH = 1'b1
  } command_t;

  // Classification made by the front.
  typedef enum logic [1:0] {
    CLS_HEADER = 2'd0,
    CLS_BADLEN = 2'd1,
    CLS_FINISH = 2'd2
  } class_t;

  typedef struct packed {
    logic        command;
    logic [31:0] txn_id;
    logic [1:0]  record_kind;
    logic [31:0] record_len;
  } in_item_t;

  typedef struct packed {
    action_t     action;
    status_t     txn_status;
    logic [31:0] committed_total;
    logic [31:0] aborted_total;
    logic [31:0] skipped_total;
    logic [6:0]  incomplete_total;
  } out_item_t;

  typedef struct packed {
    class_t      cls;
    logic [31:0] txn_id;
    kind_t       kind;
  } queue_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/log_transaction_state_tracker_core.sv
// Log transaction state tracker.
// Input channel: present a record header or a finish command on in_item and
// raise start; the transfer takes place at a rising edge where start is high
// and busy is low. busy is high while the two-entry queue between the
// classifying front and the table back is full.
// Result channel: each transfer produces exactly one result on out_item,
// marked by out_valid for one cycle. Results leave in input order.
// With the back idle, an accepted item goes from the queue to a match step (id
// compared against all table slots in parallel), then to an update step (table
// and counters written into the result register). The back takes no new item
// until it is through with the last; the queue absorbs short bursts at one
// item per cycle while not full. Configuration: cfg_we writes cfg_wdata to
// register cfg_index (0 maximum record length, 1 minimum record length); the
// user is to write only while the block is idle, which the block does not
// enforce. Reset (rst_n low, synchronous) empties the table and the queue,
// clears the counters and restores the length bounds. The receiver cannot
// hold results off, so out_valid is never delayed by the output side.
module log_transaction_state_tracker_core
  import ltst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        start,
  input  in_item_t    in_item,
  output logic        busy,
  output logic        out_valid,
  output out_item_t   out_item
);

  logic        push;
  logic        pop;
  queue_item_t push_item;
  queue_item_t head_item;
  q_status_t   q_status;

  // Front: length check and classification.
  ltst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // Queue decoupling front and back.
  ltst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_status)
  );

  // Back: table lookup, update, counters and result register.
  ltst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (head_item),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: rtl/ltst_queue.sv
module ltst_queue
  import ltst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  queue_item_t push_item,
  input  logic        pop,
  output queue_item_t head_item,
  output q_status_t   status
);

  queue_item_t slots_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r;
  logic [QP_W-1:0] rd_ptr_r;
  logic [QC_W-1:0] fill_r;
  logic [QP_W-1:0] wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_nxt;
  logic [QC_W-1:0] fill_nxt;

  // Pointers wrap naturally since the depth is a power of two.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Storage needs no reset; the fill count guards it.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item    = slots_r[rd_ptr_r];
  assign status.full  = (fill_r == QC_W'(QUEUE_DEPTH));
  assign status.empty = (fill_r == '0);

endmodule

// File: rtl/ltst_front.sv
module ltst_front
  import ltst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        start,
  input  in_item_t    in_item,
  output logic        busy,
  input  q_status_t   q_status,
  output logic        push,
  output queue_item_t push_item
);

  logic [31:0] max_len_r;
  logic [15:0] min_len_r;
  logic        len_bad;

  // Length bound registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
      min_len_r <= MIN_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_LEN: max_len_r <= cfg_wdata;
        CFG_MIN_LEN: min_len_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // A transfer is taken whenever the queue has room.
  assign busy = q_status.full;
  assign push = start && !busy;

  // Classify the item so the back never needs the length or the bounds.
  assign len_bad = (in_item.record_len < 32'(min_len_r)) || (in_item.record_len > max_len_r);

  always_comb begin
    if (in_item.command == CMD_FINISH) begin
      push_item.cls = CLS_FINISH;
    end else if (len_bad) begin
      push_item.cls = CLS_BADLEN;
    end else begin
      push_item.cls = CLS_HEADER;
    end
    push_item.txn_id = in_item.txn_id;
    push_item.kind   = kind_t'(in_item.record_kind);
  end

endmodule

// File: rtl/ltst_back.sv
module ltst_back
  import ltst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  queue_item_t head_item,
  input  q_status_t   q_status,
  output logic        pop,
  output logic        out_valid,
  output out_item_t   out_item
);

  typedef enum logic [1:0] {
    S_MATCH  = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Transaction table; only slots below the entry count are ever valid.
  logic [31:0] entry_id_r     [TABLE_SLOTS];
  status_t     entry_status_r [TABLE_SLOTS];
  logic [CNT_W-1:0] entry_count_r;
  logic [CNT_W-1:0] entry_count_nxt;
  logic [CNT_W-1:0] in_prog_r;
  logic [CNT_W-1:0] in_prog_nxt;

  logic [31:0] commit_r;
  logic [31:0] commit_nxt;
  logic [31:0] abort_r;
  logic [31:0] abort_nxt;
  logic [31:0] skip_r;
  logic [31:0] skip_nxt;

  queue_item_t item_r;
  logic [TABLE_SLOTS-1:0] hit_r;
  logic [TABLE_SLOTS-1:0] hit_nxt;

  logic        out_valid_r;
  out_item_t   out_item_r;
  out_item_t   res;

  logic             any_hit;
  logic [1:0]       old_bits;
  status_t          old_st;
  status_t          new_st;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             id_we;
  logic             st_we;
  logic             control;

  // Parallel compare of the head id against every valid slot.
  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      hit_nxt[i] = (CNT_W'(i) < entry_count_r) && (entry_id_r[i] == head_item.txn_id);
    end
  end

  assign pop = (state_r == S_MATCH) && !q_status.empty;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_MATCH:  if (!q_status.empty) state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_MATCH;
      default:  state_nxt = S_MATCH;
    endcase
  end

  // Ids in the table are unique, so the match vector is one-hot or empty.
  always_comb begin
    old_bits = '0;
    hit_idx  = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (hit_r[i]) begin
        old_bits = old_bits | entry_status_r[i];
        hit_idx  = hit_idx | IDX_W'(i);
      end
    end
  end

  assign any_hit = |hit_r;
  assign old_st  = status_t'(old_bits);
  assign control = (item_r.kind == KIND_CHECKPOINT) || (item_r.kind == KIND_COMMIT)
                || (item_r.kind == KIND_ABORT);

  // Update of table and counters for the item in hand.
  always_comb begin
    entry_count_nxt = entry_count_r;
    in_prog_nxt     = in_prog_r;
    commit_nxt      = commit_r;
    abort_nxt       = abort_r;
    skip_nxt        = skip_r;
    new_st          = ST_NONE;
    wr_idx          = any_hit ? hit_idx : entry_count_r[IDX_W-1:0];
    id_we           = 1'b0;
    st_we           = 1'b0;
    res.action      = ACT_FORWARD;
    res.incomplete_total = '0;

    if (state_r == S_UPDATE) begin
      case (item_r.cls)
        CLS_FINISH: begin
          res.action           = ACT_FINISH;
          res.incomplete_total = 7'(in_prog_r);
        end
        CLS_BADLEN: begin
          res.action = ACT_BADLEN;
        end
        CLS_HEADER: begin
          if (item_r.txn_id != '0 && !any_hit
              && entry_count_r >= CNT_W'(TABLE_SLOTS)) begin
            res.action = ACT_FULL;
          end else begin
            if (item_r.txn_id != '0) begin
              st_we = 1'b1;
              if (!any_hit) begin
                id_we           = 1'b1;
                entry_count_nxt = entry_count_r + 1'b1;
              end
              case (item_r.kind)
                KIND_COMMIT: begin
                  new_st     = ST_COMMITTED;
                  commit_nxt = commit_r + 32'd1;
                end
                KIND_ABORT: begin
                  new_st    = ST_ABORTED;
                  abort_nxt = abort_r + 32'd1;
                end
                default: new_st = any_hit ? old_st : ST_PROGRESS;
              endcase
              // Track the number of in-progress entries as they change.
              if ((new_st == ST_PROGRESS) && !(any_hit && old_st == ST_PROGRESS)) begin
                in_prog_nxt = in_prog_r + 1'b1;
              end else if ((new_st != ST_PROGRESS) && any_hit && old_st == ST_PROGRESS) begin
                in_prog_nxt = in_prog_r - 1'b1;
              end
            end
            if (control || new_st == ST_COMMITTED) begin
              res.action = ACT_FORWARD;
            end else begin
              res.action = ACT_SKIP;
              skip_nxt   = skip_r + 32'd1;
            end
          end
        end
        default: res.action = ACT_BADLEN;
      endcase
    end

    res.txn_status      = new_st;
    res.committed_total = commit_nxt;
    res.aborted_total   = abort_nxt;
    res.skipped_total   = skip_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_MATCH;
      entry_count_r <= '0;
      in_prog_r     <= '0;
      commit_r      <= '0;
      abort_r       <= '0;
      skip_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      in_prog_r     <= in_prog_nxt;
      commit_r      <= commit_nxt;
      abort_r       <= abort_nxt;
      skip_r        <= skip_nxt;
      out_valid_r   <= (state_r == S_UPDATE);
    end
  end

  // Payload registers: item in hand, match vector, result and table contents.
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head_item;
      hit_r  <= hit_nxt;
    end
    if (state_r == S_UPDATE) begin
      out_item_r <= res;
    end
    if (id_we) begin
      entry_id_r[wr_idx] <= item_r.txn_id;
    end
    if (st_we) begin
      entry_status_r[wr_idx] <= new_st;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: tb/log_transaction_state_tracker_core_test.sv
module log_transaction_state_tracker_core_test;
  import ltst_pkg::*;

  // Cycles without any transfer on either side before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Distinct transaction ids drawn from during the random part.
  localparam int POOL_IDS = 96;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_MAX_LEN;
  logic [31:0] cfg_wdata = '0;
  logic        start = 1'b0;
  in_item_t    in_item = '0;
  logic        busy;
  logic        out_valid;
  out_item_t   out_item;

  // Shadow of the block: length bounds, transaction table and counters.
  logic [31:0] lim_max = MAX_LEN_RESET;
  logic [15:0] lim_min = MIN_LEN_RESET;
  logic [31:0] tbl_id [TABLE_SLOTS];
  status_t     tbl_status [TABLE_SLOTS];
  int          tbl_used = 0;
  logic [31:0] n_commit = '0;
  logic [31:0] n_abort = '0;
  logic [31:0] n_skip = '0;

  out_item_t   results_due [$];
  dir_row_t    directed [$];
  logic [31:0] id_pool [POOL_IDS];
  int          sent = 0;
  int          results_seen = 0;
  int          errors = 0;
  int          stall_cycles = 0;
  bit          burst = 1'b0;

  always #1 clk = ~clk;

  log_transaction_state_tracker_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Fill in a result with the counters as they stand now.
  function automatic out_item_t stamp(action_t a, status_t s, logic [6:0] inc);
    out_item_t r;
    r.action           = a;
    r.txn_status       = s;
    r.committed_total  = n_commit;
    r.aborted_total    = n_abort;
    r.skipped_total    = n_skip;
    r.incomplete_total = inc;
    return r;
  endfunction

  // Classify one accepted transfer, update the shadow table and return the result.
  function automatic out_item_t track_record(in_item_t it);
    int      slot;
    int      n;
    status_t st;
    slot = -1;
    n    = 0;
    st   = ST_NONE;
    if (it.command == CMD_FINISH) begin
      for (int i = 0; i < tbl_used; i++) begin
        if (tbl_status[i] == ST_PROGRESS) n++;
      end
      return stamp(ACT_FINISH, ST_NONE, n[6:0]);
    end
    if (it.record_len < {16'd0, lim_min} || it.record_len > lim_max) begin
      return stamp(ACT_BADLEN, ST_NONE, '0);
    end
    if (it.txn_id != '0) begin
      for (int i = 0; i < tbl_used; i++) begin
        if (tbl_id[i] == it.txn_id) slot = i;
      end
      if (slot < 0) begin
        if (tbl_used >= TABLE_SLOTS) return stamp(ACT_FULL, ST_NONE, '0);
        slot             = tbl_used;
        tbl_id[slot]     = it.txn_id;
        tbl_status[slot] = ST_PROGRESS;
        tbl_used++;
      end
      if (it.record_kind == KIND_COMMIT) begin
        tbl_status[slot] = ST_COMMITTED;
        n_commit++;
      end else if (it.record_kind == KIND_ABORT) begin
        tbl_status[slot] = ST_ABORTED;
        n_abort++;
      end
      st = tbl_status[slot];
    end
    // Control records and records of committed transactions pass through.
    if (it.record_kind != KIND_DATA || st == ST_COMMITTED) begin
      return stamp(ACT_FORWARD, st, '0);
    end
    n_skip++;
    return stamp(ACT_SKIP, st, '0);
  endfunction

  function automatic in_item_t rec(logic [31:0] id, kind_t k, logic [31:0] len);
    in_item_t it;
    it.command     = CMD_RECORD;
    it.txn_id      = id;
    it.record_kind = k;
    it.record_len  = len;
    return it;
  endfunction

  // The header fields of a finish command carry junk that must be ignored.
  function automatic in_item_t fin(logic [31:0] id, logic [31:0] len);
    in_item_t it;
    it.command     = CMD_FINISH;
    it.txn_id      = id;
    it.record_kind = KIND_ABORT;
    it.record_len  = len;
    return it;
  endfunction

  function automatic out_item_t res(action_t a, status_t s, logic [31:0] c,
                                    logic [31:0] ab, logic [31:0] sk);
    out_item_t r;
    r.action           = a;
    r.txn_status       = s;
    r.committed_total  = c;
    r.aborted_total    = ab;
    r.skipped_total    = sk;
    r.incomplete_total = '0;
    return r;
  endfunction

  task automatic add_row(in_item_t it, bit typed, out_item_t w);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = w;
    directed.push_back(row);
  endtask

  // Random record: mostly well-formed headers on a growing pool of ids.
  function automatic in_item_t make_record();
    in_item_t    it;
    int          r;
    int          k;
    int          pool_n;
    bit          lo_ok;
    bit          hi_ok;
    logic [31:0] lo_bound;
    r        = $urandom_range(99);
    lo_bound = {16'd0, lim_min};
    lo_ok    = (lim_min != '0);
    hi_ok    = (lim_max != 32'hFFFF_FFFF);
    pool_n   = (6 + sent / 5 > POOL_IDS) ? POOL_IDS : 6 + sent / 5;
    if (r < 5) return fin($urandom, $urandom);
    k = $urandom_range(99);
    it.command     = CMD_RECORD;
    it.txn_id      = ($urandom_range(99) < 6) ? '0 : id_pool[$urandom_range(pool_n - 1)];
    it.record_kind = (k < 45) ? KIND_DATA : (k < 60) ? KIND_CHECKPOINT :
                     (k < 80) ? KIND_COMMIT : KIND_ABORT;
    if (r < 13 && (lo_ok || hi_ok)) begin
      // Length just outside or far outside the bounds.
      if (lo_ok && (!hi_ok || $urandom_range(1) == 1)) begin
        it.record_len = ($urandom_range(1) == 1) ? lo_bound - 1 :
                        $urandom_range(lo_bound - 1, 0);
      end else begin
        it.record_len = ($urandom_range(1) == 1) ? lim_max + 1 :
                        $urandom_range(32'hFFFF_FFFF, lim_max + 1);
      end
    end else if (lo_bound > lim_max) begin
      it.record_len = $urandom;
    end else begin
      k = $urandom_range(9);
      it.record_len = (k < 2) ? lo_bound : (k < 3) ? lim_max :
                      $urandom_range(lim_max, lo_bound);
    end
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (burst || r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // Present one item and hold it until the transfer, then log its expected result.
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int          gap;
    logic [95:0] junk;
    out_item_t   r;
    gap = pick_gap();
    if (gap > 0) begin
      junk = {$urandom, $urandom, $urandom};
      start   <= 1'b0;
      in_item <= junk[$bits(in_item_t)-1:0];
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    r = track_record(it);
    results_due.push_back(typed ? want : r);
    sent++;
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both bound registers are written back to back with the enable held high.
  task automatic write_limits(logic [31:0] max_v, logic [31:0] min_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_LEN;
    cfg_wdata <= max_v;
    @(posedge clk);
    cfg_index <= CFG_MIN_LEN;
    cfg_wdata <= min_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= $urandom;
    lim_max = max_v;
    lim_min = min_word[15:0];
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR result %0d %s: got %0h, expected %0h", results_seen, what, got, want);
    errors++;
  endtask

  // Each result is checked against the oldest outstanding expectation.
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result, action", 32'(out_item.action), '0);
      end else begin
        w = results_due.pop_front();
        if (out_item.action !== w.action)
          report_mismatch("action", 32'(out_item.action), 32'(w.action));
        if (out_item.txn_status !== w.txn_status)
          report_mismatch("txn_status", 32'(out_item.txn_status), 32'(w.txn_status));
        if (out_item.committed_total !== w.committed_total)
          report_mismatch("committed_total", out_item.committed_total, w.committed_total);
        if (out_item.aborted_total !== w.aborted_total)
          report_mismatch("aborted_total", out_item.aborted_total, w.aborted_total);
        if (out_item.skipped_total !== w.skipped_total)
          report_mismatch("skipped_total", out_item.skipped_total, w.skipped_total);
        if (out_item.incomplete_total !== w.incomplete_total)
          report_mismatch("incomplete_total", 32'(out_item.incomplete_total),
                          32'(w.incomplete_total));
      end
      results_seen++;
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("log_transaction_state_tracker_core_test: done, errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] phase_max [6];
    logic [31:0] phase_min [6];
    int          phase_len [6];
    bit          dup;

    // Distinct nonzero ids; the first one has every bit set.
    id_pool[0] = 32'hFFFF_FFFF;
    for (int i = 1; i < POOL_IDS; i++) begin
      do begin
        id_pool[i] = $urandom;
        dup = (id_pool[i] == '0);
        for (int j = 0; j < i; j++) begin
          if (id_pool[j] == id_pool[i]) dup = 1'b1;
        end
      end while (dup);
    end

    // Directed rows under the reset bounds; early ones have fixed answers.
    add_row(fin(32'hFFFF_FFFF, 32'd0), 1'b1, res(ACT_FINISH, ST_NONE, 0, 0, 0));
    add_row(rec(32'd5, KIND_DATA, 32'd0), 1'b1, res(ACT_BADLEN, ST_NONE, 0, 0, 0));
    add_row(rec(32'hFFFF_FFFF, KIND_ABORT, 32'd23), 1'b1,
            res(ACT_BADLEN, ST_NONE, 0, 0, 0));
    add_row(rec(32'd5, KIND_COMMIT, 32'd16777217), 1'b1,
            res(ACT_BADLEN, ST_NONE, 0, 0, 0));
    add_row(rec(32'hFFFF_FFFF, KIND_CHECKPOINT, 32'hFFFF_FFFF), 1'b1,
            res(ACT_BADLEN, ST_NONE, 0, 0, 0));
    add_row(rec(32'd0, KIND_DATA, 32'd24), 1'b1, res(ACT_SKIP, ST_NONE, 0, 0, 1));
    add_row(rec(32'd0, KIND_CHECKPOINT, 32'd16777216), 1'b1,
            res(ACT_FORWARD, ST_NONE, 0, 0, 1));
    add_row(rec(32'd0, KIND_COMMIT, 32'd100), 1'b1, res(ACT_FORWARD, ST_NONE, 0, 0, 1));
    add_row(rec(32'd0, KIND_ABORT, 32'd24), 1'b1, res(ACT_FORWARD, ST_NONE, 0, 0, 1));
    add_row(rec(32'hFFFF_FFFF, KIND_DATA, 32'd24), 1'b0, '0);
    add_row(rec(32'hFFFF_FFFF, KIND_CHECKPOINT, 32'd1000), 1'b0, '0);
    add_row(rec(32'hFFFF_FFFF, KIND_COMMIT, 32'd24), 1'b0, '0);
    add_row(rec(32'hFFFF_FFFF, KIND_DATA, 32'd16777216), 1'b0, '0);
    add_row(rec(32'hFFFF_FFFF, KIND_ABORT, 32'd500), 1'b0, '0);
    add_row(rec(32'hFFFF_FFFF, KIND_DATA, 32'd24), 1'b0, '0);
    add_row(rec(32'd1, KIND_DATA, 32'd64), 1'b0, '0);
    add_row(rec(32'd1, KIND_COMMIT, 32'd64), 1'b0, '0);
    add_row(rec(32'd1, KIND_COMMIT, 32'd64), 1'b0, '0);
    add_row(rec(32'd1, KIND_ABORT, 32'd64), 1'b0, '0);
    add_row(rec(32'd2, KIND_CHECKPOINT, 32'd32), 1'b0, '0);
    add_row(fin(32'd0, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(rec(32'd3, KIND_COMMIT, 32'd24), 1'b0, '0);
    add_row(rec(32'h5A5A_A5A5, KIND_DATA, 32'd16777216), 1'b0, '0);
    add_row(fin(32'h0000_FFFF, 32'd7), 1'b0, '0);

    // Bound settings for the random part: widest, narrowest, empty range,
    // highest minimum, a random pair, and back to the reset values.
    phase_max = '{32'hFFFF_FFFF, 32'd1, 32'd4000, 32'hFFFF_FFFF,
                  $urandom_range(32'hFFFF_FFFF, 1), 32'd16777216};
    phase_min = '{32'h0000_0000, 32'hFFFF_0000, 32'h1234_FFFF, 32'h0000_FFFF,
                  {$urandom_range(32'hFFFF), 16'(0)} | $urandom_range(65535, 0),
                  32'h0000_0018};
    phase_len = '{90, 60, 20, 110, 110, 110};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_item(directed[i].item, directed[i].typed, directed[i].want);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_limits(phase_max[p], phase_min[p]);
      for (int n = 0; n < phase_len[p]; n++) begin
        if (n % 32 == 0) burst = ($urandom_range(3) == 0);
        if ($urandom_range(99) < 2) wait_drained();
        send_item(make_record(), 1'b0, '0);
      end
    end

    // Let the last results arrive, then watch for strays.
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("log_transaction_state_tracker_core_test: done, clean");
    end else begin
      $display("log_transaction_state_tracker_core_test: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ltst_pkg.sv
rtl/ltst_queue.sv
rtl/ltst_front.sv
rtl/ltst_back.sv
rtl/log_transaction_state_tracker_core.sv
tb/log_transaction_state_tracker_core_test.sv
